>>> rtl/sampled_curve_lerp_lookup_unit_defines.svh
// ----------------------------------------------------------------------------
// Sampled curve lookup assertion macros
// Shared concurrent assertion forms for the curve lookup unit.
// ----------------------------------------------------------------------------
`ifndef SAMPLED_CURVE_LERP_LOOKUP_UNIT_DEFINES_SVH
`define SAMPLED_CURVE_LERP_LOOKUP_UNIT_DEFINES_SVH

// Overlapping implication, checked out of reset.
`define SCLU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Non-overlapping implication, checked out of reset.
`define SCLU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sclu_pkg.sv
// ----------------------------------------------------------------------------
// Sampled curve lookup package
// Widths, register codes, shared types and helpers of the curve lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sclu_pkg;

  // Store geometry.
  localparam int MAX_FRAMES     = 1024;
  localparam int MAX_COMPONENTS = 4;
  localparam int FRAME_W        = $clog2(MAX_FRAMES);
  localparam int COMP_W         = $clog2(MAX_COMPONENTS);
  localparam int BANK_DEPTH     = MAX_FRAMES / 2;
  localparam int BANK_AW        = FRAME_W - 1;

  // Number formats.
  localparam int DATA_W   = 32;
  localparam int LEN_W    = 31;
  localparam int RATE_W   = 32;
  localparam int FRAC_W   = 32;
  localparam int PROD_W   = LEN_W + RATE_W;
  localparam int INT_W    = PROD_W - FRAC_W;
  localparam int WEIGHT_W = 16;
  localparam int CNT_W    = 3;

  // Configuration port.
  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RATE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CURVE_LENGTH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COMP_COUNT   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LAST_FRAME   = 2'd3;

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // Register file contents.
  typedef struct packed {
    logic [RATE_W-1:0]  sample_rate;
    logic [LEN_W-1:0]   curve_length;
    logic [CNT_W-1:0]   comp_count;
    logic [FRAME_W-1:0] last_frame;
  } sclu_cfg_t;

  // Frame store access issued by the index pipeline to the component lanes.
  typedef struct packed {
    logic               rd_en;
    logic               last;
    logic [BANK_AW-1:0] even_addr;
    logic [BANK_AW-1:0] odd_addr;
    logic               i0_odd;
    logic               i1_odd;
    logic [WEIGHT_W-1:0] weight;
    logic               wr_en;
    logic [COMP_W-1:0]  wr_comp;
    logic               wr_odd;
    logic [BANK_AW-1:0] wr_addr;
    logic [DATA_W-1:0]  wr_data;
  } sclu_fetch_t;

  // One bit per component that takes part in the result.
  function automatic logic [MAX_COMPONENTS-1:0] used_mask(input logic [CNT_W-1:0] count);
    logic [CNT_W-1:0]          n;
    logic [MAX_COMPONENTS-1:0] m;
    n = count;
    priority if (n == '0) begin
      n = CNT_W'(1);
    end else if (n > CNT_W'(MAX_COMPONENTS)) begin
      n = CNT_W'(MAX_COMPONENTS);
    end
    for (int c = 0; c < MAX_COMPONENTS; c++) begin
      m[c] = (CNT_W'(c) < n);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sclu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sclu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/sclu_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding rate, length, component count and bound.
// ----------------------------------------------------------------------------
`default_nettype none

module sclu_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sclu_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output sclu_pkg::sclu_cfg_t                cfg_o
);
  import sclu_pkg::*;

  sclu_cfg_t              cfg_q;
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   reg_idx;

  assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate  <= RATE_W'(32'h0001_0000);
      cfg_q.curve_length <= '0;
      cfg_q.comp_count   <= CNT_W'(1);
      cfg_q.last_frame   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SAMPLE_RATE:  cfg_q.sample_rate  <= pwdata[RATE_W-1:0];
        REG_CURVE_LENGTH: cfg_q.curve_length <= pwdata[LEN_W-1:0];
        REG_COMP_COUNT:   cfg_q.comp_count   <= pwdata[CNT_W-1:0];
        REG_LAST_FRAME:   cfg_q.last_frame   <= pwdata[FRAME_W-1:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_idx)
      REG_SAMPLE_RATE:  prdata = 32'(cfg_q.sample_rate);
      REG_CURVE_LENGTH: prdata = 32'(cfg_q.curve_length);
      REG_COMP_COUNT:   prdata = 32'(cfg_q.comp_count);
      REG_LAST_FRAME:   prdata = 32'(cfg_q.last_frame);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/sclu_index.sv
// ----------------------------------------------------------------------------
// Frame index pipeline
// Clamps the parameter, scales it by the sample rate and forms the frame
// pair and blend weight that address the banked frame store.
// ----------------------------------------------------------------------------
`default_nettype none

module sclu_index (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire logic                              req_type_i,
  input  wire logic [sclu_pkg::FRAME_W-1:0]      load_frame_i,
  input  wire logic [sclu_pkg::COMP_W-1:0]       load_component_i,
  input  wire logic [sclu_pkg::DATA_W-1:0]       sample_value_i,
  input  wire logic [sclu_pkg::DATA_W-1:0]       position_i,
  input  wire logic                              last_in_i,
  input  wire sclu_pkg::sclu_cfg_t               cfg_i,
  output sclu_pkg::sclu_fetch_t                  fetch_o
);
  import sclu_pkg::*;

  // Stage A: clamped parameter.
  logic                 a_vld_q;
  logic                 a_load_q;
  logic [FRAME_W-1:0]   a_frame_q;
  logic [COMP_W-1:0]    a_comp_q;
  logic [DATA_W-1:0]    a_data_q;
  logic                 a_last_q;
  logic [LEN_W-1:0]     a_xx_q;
  logic [LEN_W-1:0]     a_xx_d;

  // Stage B: scaled parameter split into frame and weight.
  logic                 b_vld_q;
  logic                 b_load_q;
  logic [FRAME_W-1:0]   b_frame_q;
  logic [COMP_W-1:0]    b_comp_q;
  logic [DATA_W-1:0]    b_data_q;
  logic                 b_last_q;
  logic [INT_W-1:0]     b_int_q;
  logic [WEIGHT_W-1:0]  b_w_q;
  logic [PROD_W-1:0]    prod;

  // Stage C: frame pair.
  logic                 sat;
  logic [FRAME_W-1:0]   i0;
  logic [FRAME_W-1:0]   i1;

  // Negative parameters clamp to zero, large ones to the curve length.
  always_comb begin
    priority if (position_i[DATA_W-1]) begin
      a_xx_d = '0;
    end else if (position_i[LEN_W-1:0] > cfg_i.curve_length) begin
      a_xx_d = cfg_i.curve_length;
    end else begin
      a_xx_d = position_i[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_load_q  <= (req_type_i == REQ_LOAD);
    a_frame_q <= load_frame_i;
    a_comp_q  <= load_component_i;
    a_data_q  <= sample_value_i;
    a_last_q  <= last_in_i;
    a_xx_q    <= a_xx_d;
  end

  // Q15.16 times Q16.16 gives Q31.32; the weight is the top 16 fraction bits.
  assign prod = PROD_W'(a_xx_q) * PROD_W'(cfg_i.sample_rate);

  always_ff @(posedge clk_i) begin
    b_load_q  <= a_load_q;
    b_frame_q <= a_frame_q;
    b_comp_q  <= a_comp_q;
    b_data_q  <= a_data_q;
    b_last_q  <= a_last_q;
    b_int_q   <= prod[PROD_W-1:FRAC_W];
    b_w_q     <= prod[FRAC_W-1:FRAC_W-WEIGHT_W];
  end

  // Both frames saturate at the configured last frame.
  assign sat = (b_int_q >= INT_W'(cfg_i.last_frame));
  assign i0  = sat ? cfg_i.last_frame : b_int_q[FRAME_W-1:0];
  assign i1  = sat ? cfg_i.last_frame : i0 + FRAME_W'(1);

  // Adjacent frames sit in opposite banks, so each bank sees one read.
  always_comb begin
    fetch_o.rd_en     = b_vld_q & ~b_load_q;
    fetch_o.last      = b_last_q;
    fetch_o.even_addr = i0[0] ? i1[FRAME_W-1:1] : i0[FRAME_W-1:1];
    fetch_o.odd_addr  = i0[0] ? i0[FRAME_W-1:1] : i1[FRAME_W-1:1];
    fetch_o.i0_odd    = i0[0];
    fetch_o.i1_odd    = i1[0];
    fetch_o.weight    = b_w_q;
    fetch_o.wr_en     = b_vld_q & b_load_q;
    fetch_o.wr_comp   = b_comp_q;
    fetch_o.wr_odd    = b_frame_q[0];
    fetch_o.wr_addr   = b_frame_q[FRAME_W-1:1];
    fetch_o.wr_data   = b_data_q;
  end

endmodule

`default_nettype wire

>>> rtl/sclu_lane.sv
// ----------------------------------------------------------------------------
// Component lane
// Holds one component of every frame in an even and an odd bank and blends
// the two fetched samples by the weight.
// ----------------------------------------------------------------------------
`default_nettype none

module sclu_lane (
  input  wire logic                          clk_i,
  input  wire sclu_pkg::sclu_fetch_t         fetch_i,
  input  wire logic                          wr_sel_i,
  input  wire logic                          used_i,
  output logic      [sclu_pkg::DATA_W-1:0]   value_o
);
  import sclu_pkg::*;

  logic                        even_we;
  logic                        odd_we;
  logic [DATA_W-1:0]           even_data;
  logic [DATA_W-1:0]           odd_data;

  logic                        c_i0_odd_q;
  logic                        c_i1_odd_q;
  logic [WEIGHT_W-1:0]         c_w_q;
  logic [DATA_W-1:0]           v0;
  logic [DATA_W-1:0]           v1;
  logic signed [DATA_W:0]      diff;
  logic signed [DATA_W+WEIGHT_W+1:0] prod;

  logic [DATA_W-1:0]           d_v0_q;
  logic [DATA_W-1:0]           d_step_q;
  logic [DATA_W-1:0]           sum;
  logic [DATA_W-1:0]           e_value_q;

  assign even_we = fetch_i.wr_en & wr_sel_i & ~fetch_i.wr_odd;
  assign odd_we  = fetch_i.wr_en & wr_sel_i &  fetch_i.wr_odd;

  sclu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (even_we),
    .waddr_i (fetch_i.wr_addr),
    .wdata_i (fetch_i.wr_data),
    .re_i    (fetch_i.rd_en),
    .raddr_i (fetch_i.even_addr),
    .rdata_o (even_data)
  );

  sclu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (odd_we),
    .waddr_i (fetch_i.wr_addr),
    .wdata_i (fetch_i.wr_data),
    .re_i    (fetch_i.rd_en),
    .raddr_i (fetch_i.odd_addr),
    .rdata_o (odd_data)
  );

  // Bank selects and weight travel alongside the read.
  always_ff @(posedge clk_i) begin
    c_i0_odd_q <= fetch_i.i0_odd;
    c_i1_odd_q <= fetch_i.i1_odd;
    c_w_q      <= fetch_i.weight;
  end

  // Signed difference times the unsigned weight.
  assign v0   = c_i0_odd_q ? odd_data : even_data;
  assign v1   = c_i1_odd_q ? odd_data : even_data;
  assign diff = $signed({v1[DATA_W-1], v1}) - $signed({v0[DATA_W-1], v0});
  assign prod = diff * $signed({1'b0, c_w_q});

  // The arithmetic shift by 16 rounds the step toward minus infinity.
  always_ff @(posedge clk_i) begin
    d_v0_q   <= v0;
    d_step_q <= prod[DATA_W+WEIGHT_W-1:WEIGHT_W];
  end

  // Final add; unused components read as zero.
  assign sum = d_v0_q + d_step_q;

  always_ff @(posedge clk_i) begin
    e_value_q <= used_i ? sum : '0;
  end

  assign value_o = e_value_q;

endmodule

`default_nettype wire

>>> rtl/sampled_curve_lerp_lookup_unit.sv
// An accepted item passes index stages A and B and lane stages C, D and E to the result ports.
// Throughput: one item per cycle; busy stays low, and load items yield no result.
// The rate is set by the banked frame store: one read per bank and component per cycle.
// Reset clears the pipeline valid bits and sets the registers to their defaults.
// The frame store is not cleared; frames must be loaded before they are read.
// The receiver cannot stall: every result is valid for exactly one cycle.
`default_nettype none
`include "sampled_curve_lerp_lookup_unit_defines.svh"

module sampled_curve_lerp_lookup_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sclu_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               req_type_i,
  input  wire logic [sclu_pkg::FRAME_W-1:0]       load_frame_i,
  input  wire logic [sclu_pkg::COMP_W-1:0]        load_component_i,
  input  wire logic signed [sclu_pkg::DATA_W-1:0] sample_value_i,
  input  wire logic signed [sclu_pkg::DATA_W-1:0] position_i,
  input  wire logic                               last_in_i,
  output logic                                    valid_o,
  output logic signed [sclu_pkg::DATA_W-1:0]      value0_o,
  output logic signed [sclu_pkg::DATA_W-1:0]      value1_o,
  output logic signed [sclu_pkg::DATA_W-1:0]      value2_o,
  output logic signed [sclu_pkg::DATA_W-1:0]      value3_o,
  output logic                                    last_out_o
);
  import sclu_pkg::*;

  sclu_cfg_t                 cfg;
  sclu_fetch_t               fetch;
  logic                      accept;
  logic [MAX_COMPONENTS-1:0] used;
  logic [DATA_W-1:0]         lane_value [MAX_COMPONENTS];

  logic c_vld_q, c_last_q;
  logic d_vld_q, d_last_q;
  logic e_vld_q, e_last_q;

  // The pipeline takes an item every cycle.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  sclu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sclu_index u_index (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .req_type_i       (req_type_i),
    .load_frame_i     (load_frame_i),
    .load_component_i (load_component_i),
    .sample_value_i   (sample_value_i),
    .position_i       (position_i),
    .last_in_i        (last_in_i),
    .cfg_i            (cfg),
    .fetch_o          (fetch)
  );

  assign used = used_mask(cfg.comp_count);

  // One lane per component.
  for (genvar c = 0; c < MAX_COMPONENTS; c++) begin : g_lane
    sclu_lane u_lane (
      .clk_i    (clk_i),
      .fetch_i  (fetch),
      .wr_sel_i (fetch.wr_comp == COMP_W'(c)),
      .used_i   (used[c]),
      .value_o  (lane_value[c])
    );
  end

  // Result valid and run mark follow the lane stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      c_vld_q <= fetch.rd_en;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_last_q <= fetch.last;
    d_last_q <= c_last_q;
    e_last_q <= d_last_q;
  end

  assign valid_o    = e_vld_q;
  assign last_out_o = e_last_q;
  assign value0_o   = $signed(lane_value[0]);
  assign value1_o   = $signed(lane_value[1]);
  assign value2_o   = $signed(lane_value[2]);
  assign value3_o   = $signed(lane_value[3]);

  // Every evaluate item yields a result once it has passed the lane stages.
  `SCLU_ASSERT_IMP(a_eval_result, clk_i, rst_ni, accept && (req_type_i == REQ_EVAL), ##5 valid_o, "evaluate item lost its result")

  // A load item never produces a result.
  `SCLU_ASSERT_NEXT(a_load_silent, clk_i, rst_ni, accept && (req_type_i == REQ_LOAD), ##4 !valid_o, "load item produced a result")

  // The run mark stays with its item.
  `SCLU_ASSERT_IMP(a_last_follows, clk_i, rst_ni, valid_o, last_out_o == $past(last_in_i, 5), "run mark out of step")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Curve lookup unit testbench
// Loads sample frames and evaluates the curve under a series of register
// settings. The results are compared field by field against an in-bench
// fixed-point interpolator that keeps its own copy of the frame store.
// ----------------------------------------------------------------------------

module tb_top;
  import sclu_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 72;

  // One pending item for the driver.
  typedef struct packed {
    logic               req;
    logic [FRAME_W-1:0] frame;
    logic [COMP_W-1:0]  comp;
    logic [DATA_W-1:0]  sample;
    logic [DATA_W-1:0]  pos;
    logic               last;
    logic               hold;
  } lookup_req_t;

  // One expected interpolation result.
  typedef struct packed {
    logic [MAX_COMPONENTS-1:0][DATA_W-1:0] value;
    logic                                  last;
  } lerp_point_t;

  logic                      clk_i            = 1'b0;
  logic                      rst_ni           = 1'b0;
  logic                      psel             = 1'b0;
  logic                      penable          = 1'b0;
  logic                      pwrite           = 1'b0;
  logic [PADDR_W-1:0]        paddr            = '0;
  logic [31:0]               pwdata           = '0;
  logic [31:0]               prdata;
  logic                      pready;
  logic                      start            = 1'b0;
  logic                      busy;
  logic                      req_type_i       = REQ_LOAD;
  logic [FRAME_W-1:0]        load_frame_i     = '0;
  logic [COMP_W-1:0]         load_component_i = '0;
  logic signed [DATA_W-1:0]  sample_value_i   = '0;
  logic signed [DATA_W-1:0]  position_i       = '0;
  logic                      last_in_i        = 1'b0;
  logic                      valid_o;
  logic signed [DATA_W-1:0]  value0_o;
  logic signed [DATA_W-1:0]  value1_o;
  logic signed [DATA_W-1:0]  value2_o;
  logic signed [DATA_W-1:0]  value3_o;
  logic                      last_out_o;

  // Register copy, starting at the reset values.
  logic [RATE_W-1:0]  rate_cfg   = 32'h0001_0000;
  logic [LEN_W-1:0]   length_cfg = '0;
  logic [CNT_W-1:0]   count_cfg  = 3'd1;
  logic [FRAME_W-1:0] lastf_cfg  = '0;

  // Frame store copy, and which entries the stimulus has written so far.
  logic [DATA_W-1:0] frame_copy   [MAX_FRAMES][MAX_COMPONENTS];
  bit                frame_loaded [MAX_FRAMES][MAX_COMPONENTS];

  lookup_req_t lookup_reqs [$];
  lerp_point_t due_lerps [$];
  string       reg_names [4] = '{"sample_rate", "curve_length", "component_count",
                                 "last_frame"};

  int   fails        = 0;
  int   gap_pct      = 17;
  int   queued       = 0;
  int   stall_cycles = 0;
  logic took_item    = 1'b0;

  sampled_curve_lerp_lookup_unit uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Number of components that take part in a result.
  function automatic int used_count();
    if (count_cfg == '0) return 1;
    if (count_cfg > CNT_W'(MAX_COMPONENTS)) return MAX_COMPONENTS;
    return int'(count_cfg);
  endfunction

  // Clamp the parameter, scale it by the rate and split it into frames and weight.
  function automatic void locate(input logic [DATA_W-1:0] pos,
                                 output logic [FRAME_W-1:0] f0,
                                 output logic [FRAME_W-1:0] f1,
                                 output logic [WEIGHT_W-1:0] wt);
    logic [LEN_W-1:0] xx;
    logic [63:0]      prod;
    logic [31:0]      whole;
    if (pos[DATA_W-1]) begin
      xx = '0;
    end else if (pos[LEN_W-1:0] > length_cfg) begin
      xx = length_cfg;
    end else begin
      xx = pos[LEN_W-1:0];
    end
    prod  = 64'(xx) * 64'(rate_cfg);
    whole = prod[63:32];
    wt    = prod[31:16];
    if (whole >= 32'(lastf_cfg)) begin
      f0 = lastf_cfg;
      f1 = lastf_cfg;
    end else begin
      f0 = whole[FRAME_W-1:0];
      f1 = f0 + 1'b1;
    end
  endfunction

  // a + floor((b - a) * wt / 2^16), all in Q16.16.
  function automatic logic [DATA_W-1:0] blend_q16(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b,
                                                  input logic [WEIGHT_W-1:0] wt);
    longint lo, hi, slope;
    lo    = longint'($signed(a));
    hi    = longint'($signed(b));
    slope = (hi - lo) * longint'({16'h0, wt});
    return DATA_W'(lo + (slope >>> 16));
  endfunction

  function automatic lerp_point_t predict_lerp(input logic [DATA_W-1:0] pos,
                                               input logic last);
    lerp_point_t        pt;
    logic [FRAME_W-1:0] f0, f1;
    logic [WEIGHT_W-1:0] wt;
    pt = '0;
    locate(pos, f0, f1, wt);
    for (int c = 0; c < used_count(); c++) begin
      pt.value[c] = blend_q16(frame_copy[f0][c], frame_copy[f1][c], wt);
    end
    pt.last = last;
    return pt;
  endfunction

  function automatic logic [31:0] reg_image(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_SAMPLE_RATE:  return rate_cfg;
      REG_CURVE_LENGTH: return 32'(length_cfg);
      REG_COMP_COUNT:   return 32'(count_cfg);
      REG_LAST_FRAME:   return 32'(lastf_cfg);
      default:          return '0;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fails++;
    end
  endtask

  // One configuration transfer: setup cycle, then access until pready.
  task automatic apb_xfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic [REG_IDX_W-1:0] idx);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    check_field(reg_names[idx], reg_image(idx), rd);
  endtask

  // Write a register, keep the copy in step, and read it back.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, data, rd);
    case (idx)
      REG_SAMPLE_RATE:  rate_cfg   = data;
      REG_CURVE_LENGTH: length_cfg = data[LEN_W-1:0];
      REG_COMP_COUNT:   count_cfg  = data[CNT_W-1:0];
      REG_LAST_FRAME:   lastf_cfg  = data[FRAME_W-1:0];
      default: ;
    endcase
    check_reg(idx);
  endtask

  task automatic queue_load(input logic [FRAME_W-1:0] frame, input logic [COMP_W-1:0] comp,
                            input logic [DATA_W-1:0] value);
    lookup_req_t it;
    it.req    = REQ_LOAD;
    it.frame  = frame;
    it.comp   = comp;
    it.sample = value;
    it.pos    = $urandom;
    it.last   = 1'($urandom);
    it.hold   = 1'b0;
    lookup_reqs.push_back(it);
    frame_loaded[frame][comp] = 1'b1;
    queued++;
  endtask

  // Queue an evaluate item, first loading any entry it reads that was never written.
  task automatic queue_eval(input logic [DATA_W-1:0] pos, input logic last, input bit hold);
    lookup_req_t        it;
    logic [FRAME_W-1:0] f0, f1;
    logic [WEIGHT_W-1:0] wt;
    locate(pos, f0, f1, wt);
    for (int c = 0; c < used_count(); c++) begin
      if (!frame_loaded[f0][c]) queue_load(f0, COMP_W'(c), $urandom);
      if (!frame_loaded[f1][c]) queue_load(f1, COMP_W'(c), $urandom);
    end
    it.req    = REQ_EVAL;
    it.frame  = FRAME_W'($urandom);
    it.comp   = COMP_W'($urandom);
    it.sample = $urandom;
    it.pos    = pos;
    it.last   = last;
    it.hold   = hold;
    lookup_reqs.push_back(it);
    queued++;
  endtask

  // Wait until every item is taken and every result has come, then let the pipe empty.
  task automatic settle();
    while (lookup_reqs.size() != 0 || start || due_lerps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Driver: present the next item at the falling edge once the last one is taken.
  always @(negedge clk_i) begin : drive_lookups
    lookup_req_t it;
    if (rst_ni && (!start || took_item)) begin
      if (lookup_reqs.size() != 0 && $urandom_range(0, 99) >= gap_pct &&
          !(lookup_reqs[0].hold && due_lerps.size() != 0)) begin
        it = lookup_reqs.pop_front();
        req_type_i       <= it.req;
        load_frame_i     <= it.frame;
        load_component_i <= it.comp;
        sample_value_i   <= it.sample;
        position_i       <= it.pos;
        last_in_i        <= it.last;
        start            <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results, then record the item taken at this edge.
  always @(posedge clk_i) begin : watch_results
    lerp_point_t                           want;
    logic [MAX_COMPONENTS-1:0][DATA_W-1:0] got;
    if (rst_ni) begin
      if (valid_o) begin
        got = {value3_o, value2_o, value1_o, value0_o};
        if (due_lerps.size() == 0) begin
          $error("result with no evaluate item outstanding");
          fails++;
        end else begin
          want = due_lerps.pop_front();
          for (int c = 0; c < MAX_COMPONENTS; c++) begin
            check_field($sformatf("value%0d", c), want.value[c], got[c]);
          end
          check_field("last_out", 32'(want.last), 32'(last_out_o));
        end
      end
      if (start && !busy) begin
        if (req_type_i == REQ_LOAD) begin
          frame_copy[load_frame_i][load_component_i] = sample_value_i;
        end else begin
          due_lerps.push_back(predict_lerp(position_i, last_in_i));
        end
      end
    end
    took_item <= rst_ni && start && !busy;
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0]       rate, len, pos;
    logic [CNT_W-1:0]  cnt;
    int                lf, run;
    logic [63:0]       span;
    logic              end_mark;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values of every register.
    check_reg(REG_SAMPLE_RATE);
    check_reg(REG_CURVE_LENGTH);
    check_reg(REG_COMP_COUNT);
    check_reg(REG_LAST_FRAME);

    // Reset setting: zero curve length pins every parameter to frame zero.
    queue_load(0, 0, 32'h7FFF_FFFF);
    queue_eval(32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_eval(32'h7FFF_FFFF, 1'b0, 1'b0);
    queue_eval(32'h8000_0000, 1'b1, 1'b0);
    settle();

    // Three frames of two components with extreme values; upper write bits are junk.
    write_reg(REG_SAMPLE_RATE, 32'h0001_0000);
    write_reg(REG_CURVE_LENGTH, 32'h8002_8000);
    write_reg(REG_COMP_COUNT, 32'hFFFF_FFFA);
    write_reg(REG_LAST_FRAME, 32'hFFFF_FC02);
    queue_load(0, 0, 32'h8000_0000);
    queue_load(0, 1, 32'h7FFF_FFFF);
    queue_load(1, 0, 32'h7FFF_FFFF);
    queue_load(1, 1, 32'h8000_0000);
    queue_load(2, 0, 32'hFFFF_FFFF);
    queue_load(2, 1, 32'h1234_5678);
    // Largest weight across the full range, both slope signs.
    queue_eval(32'h0000_FFFF, 1'b0, 1'b0);
    // Half weight, negative slope on component 0; the sender waits for all results first.
    queue_eval(32'h0001_8000, 1'b0, 1'b1);
    // Parameter at the last frame, then just below the curve length; both pairs saturate there.
    queue_eval(32'h0002_0000, 1'b0, 1'b0);
    queue_eval(32'h0002_7FFF, 1'b1, 1'b0);
    // Above the curve length and negative.
    queue_eval(32'h7FFF_FFFF, 1'b0, 1'b0);
    queue_eval(32'h8000_0000, 1'b1, 1'b0);
    settle();

    // Random phases, each under its own register setting.
    for (int p = 0; p < 9; p++) begin
      case (p % 5)
        0: begin
          rate = '1;
          len  = 32'h7FFF_FFFF;
          cnt  = 3'd7;
          lf   = MAX_FRAMES - 1;
        end
        1: begin
          rate = '0;
          len  = $urandom;
          cnt  = '0;
          lf   = $urandom_range(0, MAX_FRAMES - 1);
        end
        2: begin
          // Spread the parameter range up to two frames past the last one.
          if ($urandom_range(0, 1) != 0) len = $urandom_range(1, 32'hFFFF);
          else len = $urandom_range(1, 32'h7FFF_FFFF);
          lf   = $urandom_range(1, 40);
          cnt  = CNT_W'($urandom_range(1, MAX_COMPONENTS));
          span = (64'(lf + 2) << 32) / 64'(len[LEN_W-1:0]);
          rate = (span > 64'hFFFF_FFFF) ? '1 : span[31:0];
        end
        3: begin
          rate = $urandom;
          len  = (p < 5) ? '0 : $urandom;
          cnt  = CNT_W'($urandom_range(5, 7));
          lf   = 0;
        end
        default: begin
          rate = $urandom;
          len  = $urandom;
          cnt  = CNT_W'($urandom);
          lf   = $urandom_range(0, MAX_FRAMES - 1);
        end
      endcase
      write_reg(REG_SAMPLE_RATE, rate);
      write_reg(REG_CURVE_LENGTH, {1'($urandom), len[LEN_W-1:0]});
      write_reg(REG_COMP_COUNT, {29'($urandom), cnt});
      write_reg(REG_LAST_FRAME, {22'($urandom), FRAME_W'(lf)});

      gap_pct = (p == 2) ? 0 : 17;
      queued  = 0;
      while (queued < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          // Stray load anywhere in the store.
          queue_load(FRAME_W'($urandom), COMP_W'($urandom), $urandom);
        end else begin
          // Vector run; a few runs lose or gain a last mark.
          run = $urandom_range(1, 6);
          for (int k = 0; k < run; k++) begin
            if (k == run - 1) end_mark = ($urandom_range(0, 9) != 0);
            else end_mark = ($urandom_range(0, 19) == 0);
            case ($urandom_range(0, 9))
              0: pos = '0;
              1: pos = 32'(length_cfg);
              2: pos = {1'b1, 31'($urandom)};
              3: pos = $urandom;
              4: pos = $urandom_range(0, 2047);
              5: pos = 32'(length_cfg) + $urandom_range(1, 4096);
              default: pos = $urandom_range(0, 32'(length_cfg));
            endcase
            queue_eval(pos, end_mark, k == 0 && $urandom_range(0, 29) == 0);
          end
        end
      end
      settle();
    end

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
